[rtl/hrs_pkg.sv]
`timescale 1ns / 1ps

package hrs_pkg;

    // Coordinate format: signed Q(COORD_WIDTH-8).8
    localparam int COORD_WIDTH = 24;
    localparam int COEF_W      = 32;
    localparam int PROD_W      = COEF_W + COORD_WIDTH;
    localparam int ACC_W       = 66;
    localparam int P_W         = 64;
    localparam int TRANS_SHIFT = 24;
    localparam int SCALE_SHIFT = 20;
    localparam int FRAC_SHIFT  = 20;
    localparam int QUO_W       = 40;
    localparam int DIV_STEPS   = QUO_W;
    localparam int MAG_W       = QUO_W + 1;
    localparam int DIFF_W      = MAG_W + 2;
    localparam int ABS_W       = 25;
    localparam int SQ_W        = 2 * ABS_W;
    localparam int ERR_W       = 48;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_DATA_W   = ((4 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ERR_W;
    localparam int OUT_USER_W  = 8;

    localparam logic [ERR_W-1:0] ERR_MAX   = {ERR_W{1'b1}};
    localparam logic [DIFF_W-1:0] DIFF_LIM = DIFF_W'(1) << 24;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_ZERO_DEN = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIN0  = 3'd0,
        CFG_LIN1  = 3'd1,
        CFG_TRANS = 3'd2,
        CFG_PERSP = 3'd3,
        CFG_SCALE = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0] h00, h01, h02;
        logic signed [COEF_W-1:0] h10, h11, h12;
        logic signed [COEF_W-1:0] h20, h21, h22;
    } t_hom_cfg;

    // Projected numerators and denominator as magnitudes plus signs
    typedef struct packed {
        logic [P_W-1:0]                nx, ny, den;
        logic                          neg_x, neg_y;
        logic signed [COORD_WIDTH-1:0] tx, ty;
        t_status                       status;
    } t_aff_out;

    // Mapped coordinate magnitudes, Q.8, capped at 2^40
    typedef struct packed {
        logic [MAG_W-1:0]              mx, my;
        logic                          neg_x, neg_y;
        logic signed [COORD_WIDTH-1:0] tx, ty;
        t_status                       status;
    } t_div_out;

    // True when a wide sum still fits a signed 64-bit value
    function automatic logic fits64(input logic signed [ACC_W-1:0] v);
        return v[ACC_W-1:P_W-1] == {(ACC_W-P_W+1){v[P_W-1]}};
    endfunction

endpackage

[rtl/hrs_affine.sv]
`timescale 1ns / 1ps

module hrs_affine (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic signed [hrs_pkg::COORD_WIDTH-1:0] i_sx,
    input  logic signed [hrs_pkg::COORD_WIDTH-1:0] i_sy,
    input  logic signed [hrs_pkg::COORD_WIDTH-1:0] i_tx,
    input  logic signed [hrs_pkg::COORD_WIDTH-1:0] i_ty,
    input  hrs_pkg::t_hom_cfg                      i_cfg,
    output logic                                   o_valid,
    output hrs_pkg::t_aff_out                      o_data
);

    localparam int PW = hrs_pkg::PROD_W;
    localparam int AW = hrs_pkg::ACC_W;
    localparam int CW = hrs_pkg::COORD_WIDTH;

    // Stage 1: products
    logic                 r_v1;
    logic signed [PW-1:0] r_m00, r_m01, r_m10, r_m11, r_m20, r_m21;
    logic signed [CW-1:0] r_tx1, r_ty1;

    // Stage 2: sums with range checks
    logic                         r_v2, r_ovf01, r_ovf2;
    logic signed [hrs_pkg::P_W-1:0] r_p0, r_p1, r_p2;
    logic signed [CW-1:0]         r_tx2, r_ty2;

    // Stage 3: magnitudes and status
    logic              r_v3;
    hrs_pkg::t_aff_out r_out;

    logic signed [AW-1:0] n_t0, n_t1, n_t2, n_p0, n_p1, n_p2;
    logic signed [AW-1:0] n_c0, n_c1, n_c2;
    hrs_pkg::t_aff_out    n_out;

    // Form the three affine sums in 66 bits, check each partial sum
    always_comb begin
        n_c0 = AW'(i_cfg.h02) <<< hrs_pkg::TRANS_SHIFT;
        n_c1 = AW'(i_cfg.h12) <<< hrs_pkg::TRANS_SHIFT;
        n_c2 = AW'(i_cfg.h22) <<< hrs_pkg::SCALE_SHIFT;
        n_t0 = AW'(r_m00) + AW'(r_m01);
        n_t1 = AW'(r_m10) + AW'(r_m11);
        n_t2 = AW'(r_m20) + AW'(r_m21);
        n_p0 = n_t0 + n_c0;
        n_p1 = n_t1 + n_c1;
        n_p2 = n_t2 + n_c2;
    end

    // Take magnitudes, pick status by precedence
    always_comb begin
        n_out.nx    = r_p0[hrs_pkg::P_W-1] ? (~r_p0 + 1'b1) : r_p0;
        n_out.ny    = r_p1[hrs_pkg::P_W-1] ? (~r_p1 + 1'b1) : r_p1;
        n_out.den   = r_p2[hrs_pkg::P_W-1] ? (~r_p2 + 1'b1) : r_p2;
        n_out.neg_x = r_p0[hrs_pkg::P_W-1] ^ r_p2[hrs_pkg::P_W-1];
        n_out.neg_y = r_p1[hrs_pkg::P_W-1] ^ r_p2[hrs_pkg::P_W-1];
        n_out.tx    = r_tx2;
        n_out.ty    = r_ty2;
        priority if (r_ovf2)
            n_out.status = hrs_pkg::ST_OVERFLOW;
        else if (r_p2 == '0)
            n_out.status = hrs_pkg::ST_ZERO_DEN;
        else if (r_ovf01)
            n_out.status = hrs_pkg::ST_OVERFLOW;
        else
            n_out.status = hrs_pkg::ST_VALID;
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m00   <= PW'(i_cfg.h00) * PW'(i_sx);
            r_m01   <= PW'(i_cfg.h01) * PW'(i_sy);
            r_m10   <= PW'(i_cfg.h10) * PW'(i_sx);
            r_m11   <= PW'(i_cfg.h11) * PW'(i_sy);
            r_m20   <= PW'(i_cfg.h20) * PW'(i_sx);
            r_m21   <= PW'(i_cfg.h21) * PW'(i_sy);
            r_tx1   <= i_tx;
            r_ty1   <= i_ty;
            r_p0    <= n_p0[hrs_pkg::P_W-1:0];
            r_p1    <= n_p1[hrs_pkg::P_W-1:0];
            r_p2    <= n_p2[hrs_pkg::P_W-1:0];
            r_ovf01 <= !hrs_pkg::fits64(n_t0) || !hrs_pkg::fits64(n_p0)
                    || !hrs_pkg::fits64(n_t1) || !hrs_pkg::fits64(n_p1);
            r_ovf2  <= !hrs_pkg::fits64(n_t2) || !hrs_pkg::fits64(n_p2);
            r_tx2   <= r_tx1;
            r_ty2   <= r_ty1;
            r_out   <= n_out;
        end
    end

    assign o_valid = r_v3;
    assign o_data  = r_out;

endmodule

[rtl/hrs_divider.sv]
`timescale 1ns / 1ps

module hrs_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  hrs_pkg::t_aff_out i_data,
    output logic              o_valid,
    output hrs_pkg::t_div_out o_data
);

    localparam int PW = hrs_pkg::P_W;
    localparam int LW = hrs_pkg::FRAC_SHIFT;
    localparam int QW = hrs_pkg::QUO_W;
    localparam int NS = hrs_pkg::DIV_STEPS;

    typedef struct packed {
        logic [PW-1:0] rem;
        logic [LW-1:0] low;
        logic [QW-1:0] quo;
        logic          cap;
    } t_lane;

    typedef struct packed {
        t_lane                                  lx, ly;
        logic [PW-1:0]                          den;
        logic                                   neg_x, neg_y;
        logic signed [hrs_pkg::COORD_WIDTH-1:0] tx, ty;
        hrs_pkg::t_status                       status;
    } t_stage;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    function automatic t_lane div_step(input t_lane a, input logic [PW-1:0] den);
        logic [PW:0] rs;
        logic [PW:0] diff;
        t_lane       b;
        rs    = {a.rem, a.low[LW-1]};
        diff  = rs - {1'b0, den};
        b     = a;
        b.low = {a.low[LW-2:0], 1'b0};
        if (!diff[PW]) begin
            b.rem = diff[PW-1:0];
            b.quo = {a.quo[QW-2:0], 1'b1};
        end else begin
            b.rem = rs[PW-1:0];
            b.quo = {a.quo[QW-2:0], 1'b0};
        end
        return b;
    endfunction

    // Seed a lane: cap when num / den reaches 2^20, so the quotient reaches 2^40
    function automatic t_lane div_init(input logic [PW-1:0] num, input logic [PW-1:0] den);
        t_lane b;
        b.cap = {{LW{1'b0}}, num} >= {den, {LW{1'b0}}};
        b.rem = num >> LW;
        b.low = num[LW-1:0];
        b.quo = '0;
        return b;
    endfunction

    logic   r_v [0:NS];
    t_stage r_st [0:NS];
    t_stage n_init;

    always_comb begin
        n_init.lx     = div_init(i_data.nx, i_data.den);
        n_init.ly     = div_init(i_data.ny, i_data.den);
        n_init.den    = i_data.den;
        n_init.neg_x  = i_data.neg_x;
        n_init.neg_y  = i_data.neg_y;
        n_init.tx     = i_data.tx;
        n_init.ty     = i_data.ty;
        n_init.status = i_data.status;
    end

    // Seed stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v[0] <= 1'b0;
        else if (i_en)
            r_v[0] <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en)
            r_st[0] <= n_init;
    end

    // One quotient bit per stage for both lanes
    for (genvar g = 0; g < NS; g++) begin : g_step
        t_stage n_st;

        always_comb begin
            n_st    = r_st[g];
            n_st.lx = div_step(r_st[g].lx, r_st[g].den);
            n_st.ly = div_step(r_st[g].ly, r_st[g].den);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n)
                r_v[g+1] <= 1'b0;
            else if (i_en)
                r_v[g+1] <= r_v[g];
        end

        always_ff @(posedge i_clk) begin
            if (i_en)
                r_st[g+1] <= n_st;
        end
    end

    // Apply the cap
    always_comb begin
        o_data.mx     = r_st[NS].lx.cap ? (hrs_pkg::MAG_W'(1) << QW)
                                        : {1'b0, r_st[NS].lx.quo};
        o_data.my     = r_st[NS].ly.cap ? (hrs_pkg::MAG_W'(1) << QW)
                                        : {1'b0, r_st[NS].ly.quo};
        o_data.neg_x  = r_st[NS].neg_x;
        o_data.neg_y  = r_st[NS].neg_y;
        o_data.tx     = r_st[NS].tx;
        o_data.ty     = r_st[NS].ty;
        o_data.status = r_st[NS].status;
    end

    assign o_valid = r_v[NS];

endmodule

[rtl/hrs_residual.sv]
`timescale 1ns / 1ps

module hrs_residual (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  hrs_pkg::t_div_out             i_data,
    output logic                          o_valid,
    output logic [hrs_pkg::ERR_W-1:0]     o_error,
    output hrs_pkg::t_status              o_status
);

    localparam int DW = hrs_pkg::DIFF_W;
    localparam int AW = hrs_pkg::ABS_W;
    localparam int SW = hrs_pkg::SQ_W;

    logic                 r_va, r_vb, r_vc, r_vd;
    logic signed [DW-1:0] r_dx, r_dy;
    hrs_pkg::t_status     r_sta, r_stb, r_stc, r_std;
    logic [AW-1:0]        r_ax, r_ay;
    logic                 r_bigb, r_bigc;
    logic [SW-1:0]        r_sqx, r_sqy;
    logic [hrs_pkg::ERR_W-1:0] r_err;

    logic signed [DW-1:0] n_tx, n_ty, n_mx, n_my, n_dx, n_dy;
    logic [DW-1:0]        n_ax, n_ay;
    logic [SW:0]          n_sum;
    hrs_pkg::t_status     n_st;
    logic [hrs_pkg::ERR_W-1:0] n_err;

    // Difference target minus mapped point
    always_comb begin
        n_tx = DW'(i_data.tx);
        n_ty = DW'(i_data.ty);
        n_mx = DW'(i_data.mx);
        n_my = DW'(i_data.my);
        n_dx = i_data.neg_x ? n_tx + n_mx : n_tx - n_mx;
        n_dy = i_data.neg_y ? n_ty + n_my : n_ty - n_my;
    end

    // Absolute values
    always_comb begin
        n_ax = r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx);
        n_ay = r_dy[DW-1] ? DW'(-r_dy) : DW'(r_dy);
    end

    // Sum squares, saturate
    always_comb begin
        n_sum = (SW+1)'(r_sqx) + (SW+1)'(r_sqy);
        priority if (r_stc != hrs_pkg::ST_VALID) begin
            n_st  = r_stc;
            n_err = hrs_pkg::ERR_MAX;
        end else if (r_bigc || n_sum > (SW+1)'(hrs_pkg::ERR_MAX)) begin
            n_st  = hrs_pkg::ST_OVERFLOW;
            n_err = hrs_pkg::ERR_MAX;
        end else begin
            n_st  = hrs_pkg::ST_VALID;
            n_err = n_sum[hrs_pkg::ERR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_sta  <= i_data.status;
            r_ax   <= n_ax[AW-1:0];
            r_ay   <= n_ay[AW-1:0];
            r_bigb <= (n_ax > hrs_pkg::DIFF_LIM) || (n_ay > hrs_pkg::DIFF_LIM);
            r_stb  <= r_sta;
            r_sqx  <= r_ax * r_ax;
            r_sqy  <= r_ay * r_ay;
            r_bigc <= r_bigb;
            r_stc  <= r_stb;
            r_err  <= n_err;
            r_std  <= n_st;
        end
    end

    assign o_valid  = r_vd;
    assign o_error  = r_err;
    assign o_status = r_std;

endmodule

[rtl/homography_residual_scorer_unit.sv]
`timescale 1ns / 1ps
// Homography transfer-error scorer. Each input beat on s_axis carries one
// point correspondence: source (x, y) and target (x, y), signed Q16.8. The
// source point goes through the 3x3 homography held in the config registers,
// is divided by its third coordinate and compared with the target; m_axis
// returns the squared distance (unsigned Q32.16) with a status in tuser:
// valid, saturated by overflow, or zero denominator (both saturate to max).
// Config registers are written through i_cfg_we / i_cfg_index / i_cfg_data
// only while the block is idle, a rule for the user that the block does not
// enforce; unknown indexes are ignored. Throughput: one beat per cycle while
// the receiver does not stall. A beat passes 49 register stages: three affine
// stages, a seed stage and 40 restoring steps shared by the x and y dividers
// (one quotient bit each per step), four residual stages and the output
// register. Reset clears all valid bits and loads the identity homography.
// When the receiver stalls, one result lands in a skid register; s_axis_tready
// then drops and the whole pipeline holds until the output drains.

module homography_residual_scorer_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // source_x, source_y, target_x, target_y
    input  logic [hrs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // squared_error
    output logic [hrs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // result_status
    output logic [hrs_pkg::OUT_USER_W-1:0]     m_axis_tuser,
    input  logic                               i_cfg_we,
    input  logic [hrs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hrs_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int CW = hrs_pkg::COORD_WIDTH;

    hrs_pkg::t_hom_cfg r_cfg;
    logic              w_en;
    logic              w_aff_v, w_div_v, w_res_v;
    hrs_pkg::t_aff_out w_aff;
    hrs_pkg::t_div_out w_div;
    logic [hrs_pkg::ERR_W-1:0] w_err;
    hrs_pkg::t_status  w_st;

    logic                      r_out_v, r_skid_v;
    logic [hrs_pkg::ERR_W-1:0] r_out_err, r_skid_err;
    hrs_pkg::t_status          r_out_st, r_skid_st;

    // Config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.h00 <= 32'sh1000_0000;
            r_cfg.h01 <= '0;
            r_cfg.h02 <= '0;
            r_cfg.h10 <= '0;
            r_cfg.h11 <= 32'sh1000_0000;
            r_cfg.h12 <= '0;
            r_cfg.h20 <= '0;
            r_cfg.h21 <= '0;
            r_cfg.h22 <= 32'sh1000_0000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hrs_pkg::CFG_LIN0: begin
                    r_cfg.h00 <= i_cfg_data[31:0];
                    r_cfg.h01 <= i_cfg_data[63:32];
                end
                hrs_pkg::CFG_LIN1: begin
                    r_cfg.h10 <= i_cfg_data[31:0];
                    r_cfg.h11 <= i_cfg_data[63:32];
                end
                hrs_pkg::CFG_TRANS: begin
                    r_cfg.h02 <= i_cfg_data[31:0];
                    r_cfg.h12 <= i_cfg_data[63:32];
                end
                hrs_pkg::CFG_PERSP: begin
                    r_cfg.h20 <= i_cfg_data[31:0];
                    r_cfg.h21 <= i_cfg_data[63:32];
                end
                hrs_pkg::CFG_SCALE: r_cfg.h22 <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Pipeline advances while the skid register is empty
    assign w_en          = !r_skid_v;
    assign s_axis_tready = w_en;

    hrs_affine u_affine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_sx    (s_axis_tdata[CW-1:0]),
        .i_sy    (s_axis_tdata[2*CW-1:CW]),
        .i_tx    (s_axis_tdata[3*CW-1:2*CW]),
        .i_ty    (s_axis_tdata[4*CW-1:3*CW]),
        .i_cfg   (r_cfg),
        .o_valid (w_aff_v),
        .o_data  (w_aff)
    );

    hrs_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_aff_v),
        .i_data  (w_aff),
        .o_valid (w_div_v),
        .o_data  (w_div)
    );

    hrs_residual u_residual (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_div_v),
        .i_data   (w_div),
        .o_valid  (w_res_v),
        .o_error  (w_err),
        .o_status (w_st)
    );

    // Output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (m_axis_tready || !r_out_v) begin
            r_out_v  <= r_skid_v || w_res_v;
            r_skid_v <= 1'b0;
        end else if (w_res_v && w_en) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_axis_tready || !r_out_v) begin
            r_out_err <= r_skid_v ? r_skid_err : w_err;
            r_out_st  <= r_skid_v ? r_skid_st : w_st;
        end else if (w_res_v && w_en) begin
            r_skid_err <= w_err;
            r_skid_st  <= w_st;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_err;
    assign m_axis_tuser  = hrs_pkg::OUT_USER_W'(r_out_st);

endmodule

[rtl/hrs_checker.sv]
`timescale 1ns / 1ps

module hrs_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [hrs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [hrs_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    // Result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // Input backpressure only follows an output stall
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

    // Flagged results are saturated
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != '0 |-> m_axis_tdata == hrs_pkg::ERR_MAX)
        else $error("flagged result not saturated");

    // Status code in range
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser == hrs_pkg::OUT_USER_W'(hrs_pkg::ST_VALID)
            || m_axis_tuser == hrs_pkg::OUT_USER_W'(hrs_pkg::ST_OVERFLOW)
            || m_axis_tuser == hrs_pkg::OUT_USER_W'(hrs_pkg::ST_ZERO_DEN))
        else $error("bad status code");

endmodule

bind homography_residual_scorer_unit hrs_checker u_hrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
